[sv/srbb_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the ray to body boundary test.
// No dependencies.
package srbb_pkg;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int PHI_MAX_W = 23;
    localparam int TAYLOR_TERMS = 9;
    localparam int COS_LAT = 3 + 4 * TAYLOR_TERMS;
    localparam int DIV_BITS = 16;
    localparam int FIFO_DEPTH = 4;
    localparam logic [32:0] TWO_PI_Q30 = 33'd6746518852;
    localparam logic [31:0] ONE_Q30 = 32'd1073741824;
    localparam logic [15:0] DIST_MAX = 16'hFFFF;
    localparam logic [1:0] SHAPE_RECT = 2'd1;

    typedef enum logic [2:0] {
        REG_DIST_FRONT = 3'd0,
        REG_DIST_BACK  = 3'd1,
        REG_DIST_LEFT  = 3'd2,
        REG_DIST_RIGHT = 3'd3,
        REG_SHAPE_MODE = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic signed [15:0] bearing;
        logic [15:0]        range_mm;
    } t_in_item;

    typedef struct packed {
        logic [15:0] body_distance;
        logic        inside_body;
        logic        shape_error;
    } t_out_item;

    typedef struct packed {
        logic [15:0] dist_front;
        logic [15:0] dist_back;
        logic [15:0] dist_left;
        logic [15:0] dist_right;
        logic [1:0]  shape_mode;
    } t_cfg;

    typedef struct packed {
        logic        err;
        logic        strict;
        logic [15:0] dist_side;
        logic [15:0] dist_end;
        logic [15:0] range_mm;
    } t_side;

    typedef struct packed {
        t_side                  side;
        logic [PHI_MAX_W-1:0]   phi;
        logic [PHI_MAX_W-1:0]   phi_c;
    } t_job;

    typedef struct packed {
        logic        err;
        logic        fix;
        logic        fix_max;
        logic [15:0] range_mm;
    } t_tail;

endpackage

[sv/srbb_front.sv]
`timescale 1ns / 1ps
// Front stage: wraps the bearing, picks side and end edges, forms the job.
// Depends on srbb_pkg.
module srbb_front #(
    parameter int ANGLE_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  srbb_pkg::t_in_item i_data,
    input  srbb_pkg::t_cfg    i_cfg,
    output logic              o_valid,
    input  logic              i_stall,
    output srbb_pkg::t_job    o_job
);
    import srbb_pkg::*;

    localparam int AB = ANGLE_BITS;
    localparam logic [AB-1:0] HALF = AB'(1) << (AB - 1);
    localparam logic [AB-1:0] QUARTER = AB'(1) << (AB - 2);

    logic signed [AB-1:0] w_a;
    logic [AB-1:0]        w_m;
    logic [AB-1:0]        w_phi_full;
    logic [AB-2:0]        w_phi;
    logic [AB-2:0]        w_phi_c;
    logic                 w_right;
    logic                 w_back;
    logic                 w_accept;
    t_job                 n_job;
    t_job                 r_job;
    logic                 r_valid;

    generate
        if (AB >= 16) begin : g_wide
            assign w_a = AB'($signed(i_data.bearing)) <<< (AB - 16);
        end else begin : g_narrow
            assign w_a = i_data.bearing[15 -: AB];
        end
    endgenerate

    always_comb begin
        w_right = (!w_a[AB-1] && (|w_a)) || (w_a[AB-1] && !(|w_a[AB-2:0]));
        w_m = w_a[AB-1] ? (~w_a + AB'(1)) : w_a;
        w_back = w_m > QUARTER;
        w_phi_full = w_back ? (HALF - w_m) : w_m;
        w_phi = w_phi_full[AB-2:0];
        w_phi_c = QUARTER[AB-2:0] - w_phi;
        n_job.side.err = i_cfg.shape_mode != SHAPE_RECT;
        n_job.side.strict = w_right != w_back;
        n_job.side.dist_side = w_right ? i_cfg.dist_right : i_cfg.dist_left;
        n_job.side.dist_end = w_back ? i_cfg.dist_back : i_cfg.dist_front;
        n_job.side.range_mm = i_data.range_mm;
        n_job.phi = PHI_MAX_W'(w_phi);
        n_job.phi_c = PHI_MAX_W'(w_phi_c);
    end

    assign o_stall = r_valid && i_stall;
    assign w_accept = i_valid && !o_stall;
    assign o_valid = r_valid;
    assign o_job = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_job <= n_job;
        end
    end

endmodule

[sv/srbb_fifo.sv]
`timescale 1ns / 1ps
// Short job queue between the front and back stages.
// Depends on srbb_pkg.
module srbb_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  srbb_pkg::t_job i_job,
    output logic           o_valid,
    input  logic           i_stall,
    output srbb_pkg::t_job o_job
);
    import srbb_pkg::*;

    localparam int PW = $clog2(FIFO_DEPTH);

    t_job           r_mem [FIFO_DEPTH];
    logic [PW-1:0]  r_wr;
    logic [PW-1:0]  r_rd;
    logic [PW:0]    r_cnt;
    logic           w_push;
    logic           w_pop;

    assign o_stall = r_cnt == (PW+1)'(FIFO_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_job = r_mem[r_rd];
    assign w_push = i_valid && !o_stall;
    assign w_pop = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + PW'(1);
            end
            if (w_pop) begin
                r_rd <= r_rd + PW'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + (PW+1)'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - (PW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

[sv/srbb_cos.sv]
`timescale 1ns / 1ps
// Pipelined Q30 Taylor cosine of a binary angle, output in length fraction bits.
// Depends on srbb_pkg.
module srbb_cos #(
    parameter int ANGLE_BITS = 16,
    parameter int LENGTH_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [ANGLE_BITS-2:0] i_phi,
    output logic [LENGTH_BITS:0]  o_trig
);
    import srbb_pkg::*;

    localparam int AB = ANGLE_BITS;
    localparam int LB = LENGTH_BITS;

    logic [AB+32:0]  w_x_sum;
    logic [61:0]     w_xx;
    logic [30:0]     r_x;
    logic [31:0]     r_x2;
    logic [31:0]     w_term [TAYLOR_TERMS+1];
    logic [31:0]     w_x2 [TAYLOR_TERMS+1];
    logic [33:0]     w_pos [TAYLOR_TERMS+1];
    logic [33:0]     w_neg [TAYLOR_TERMS+1];
    logic [33:0]     w_cos;
    logic [LB:0]     w_frac;
    logic [LB:0]     r_trig;

    assign w_x_sum = (AB+33)'(i_phi) * (AB+33)'(TWO_PI_Q30) + ((AB+33)'(1) << (AB - 1));
    assign w_xx = 62'(r_x) * 62'(r_x);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= w_x_sum[AB+30:AB];
            r_x2 <= w_xx[61:30];
        end
    end

    assign w_term[0] = ONE_Q30;
    assign w_x2[0] = r_x2;
    assign w_pos[0] = 34'(ONE_Q30);
    assign w_neg[0] = '0;

    generate
        for (genvar k = 1; k <= TAYLOR_TERMS; k++) begin : g_term
            localparam int D = (2 * k - 1) * (2 * k);
            localparam logic [39:0] MR = 40'((64'd1 << 40) / D);
            localparam logic [19:0] MH = MR[39:20];
            localparam logic [19:0] ML = MR[19:0];

            logic [63:0] r_p;
            logic [31:0] r_a_x2;
            logic [33:0] r_a_pos;
            logic [33:0] r_a_neg;
            logic [33:0] w_n;
            logic [33:0] r_n;
            logic [53:0] r_ph;
            logic [53:0] r_pl;
            logic [31:0] r_b_x2;
            logic [33:0] r_b_pos;
            logic [33:0] r_b_neg;
            logic [73:0] w_sum;
            logic [33:0] r_q0;
            logic [33:0] r_c_n;
            logic [31:0] r_c_x2;
            logic [33:0] r_c_pos;
            logic [33:0] r_c_neg;
            logic [33:0] w_qd;
            logic [33:0] w_r;
            logic [33:0] w_q;
            logic [31:0] r_term;
            logic [31:0] r_x2o;
            logic [33:0] r_pos;
            logic [33:0] r_neg;

            assign w_n = r_p[63:30];
            assign w_sum = {r_ph, 20'b0} + 74'(r_pl);
            assign w_qd = 34'(r_q0 * 34'(D));
            assign w_r = r_c_n - w_qd;
            assign w_q = r_q0 + 34'(w_r >= 34'(D));

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_p <= 64'(w_term[k-1]) * 64'(w_x2[k-1]);
                    r_a_x2 <= w_x2[k-1];
                    r_a_pos <= w_pos[k-1];
                    r_a_neg <= w_neg[k-1];
                    r_n <= w_n;
                    r_ph <= 54'(w_n) * 54'(MH);
                    r_pl <= 54'(w_n) * 54'(ML);
                    r_b_x2 <= r_a_x2;
                    r_b_pos <= r_a_pos;
                    r_b_neg <= r_a_neg;
                    r_q0 <= w_sum[73:40];
                    r_c_n <= r_n;
                    r_c_x2 <= r_b_x2;
                    r_c_pos <= r_b_pos;
                    r_c_neg <= r_b_neg;
                    r_term <= w_q[31:0];
                    r_x2o <= r_c_x2;
                    if ((k % 2) == 1) begin
                        r_pos <= r_c_pos;
                        r_neg <= r_c_neg + w_q;
                    end else begin
                        r_pos <= r_c_pos + w_q;
                        r_neg <= r_c_neg;
                    end
                end
            end

            assign w_term[k] = r_term;
            assign w_x2[k] = r_x2o;
            assign w_pos[k] = r_pos;
            assign w_neg[k] = r_neg;
        end
    endgenerate

    assign w_cos = (w_pos[TAYLOR_TERMS] > w_neg[TAYLOR_TERMS])
                 ? (w_pos[TAYLOR_TERMS] - w_neg[TAYLOR_TERMS]) : '0;

    generate
        if (LB >= 30) begin : g_up
            assign w_frac = (LB+1)'(w_cos[30:0]) << (LB - 30);
        end else begin : g_down
            localparam int SH = 30 - LB;
            logic [33:0] w_rnd;
            assign w_rnd = w_cos + (34'(1) << (SH - 1));
            assign w_frac = (LB+1)'(w_rnd >> SH);
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_trig <= w_frac;
        end
    end

    assign o_trig = r_trig;

endmodule

[sv/srbb_back.sv]
`timescale 1ns / 1ps
// Back stage: cosine and sine, edge choice, restoring divide, output register.
// Depends on srbb_pkg and srbb_cos.
module srbb_back #(
    parameter int ANGLE_BITS = 16,
    parameter int LENGTH_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  srbb_pkg::t_job       i_job,
    output logic                 o_valid,
    input  logic                 i_stall,
    output srbb_pkg::t_out_item  o_data
);
    import srbb_pkg::*;

    localparam int LB = LENGTH_BITS;
    localparam int LW = LB + 1;
    localparam int RW = LB + 17;

    logic            w_adv;
    logic [LB:0]     w_c;
    logic [LB:0]     w_s;
    logic            r_v [COS_LAT];
    t_side           r_sb [COS_LAT];
    logic            r_e1_v;
    t_side           r_e1_sb;
    logic [15+LW:0]  r_lhs;
    logic [15+LW:0]  r_rhs;
    logic [LB:0]     r_e1_c;
    logic [LB:0]     r_e1_s;
    logic            w_take_end;
    logic            r_e2_v;
    t_side           r_e2_sb;
    logic [15:0]     r_e2_edge;
    logic [LB:0]     r_e2_trig;
    logic [RW-1:0]   w_num;
    logic            w_sat;
    logic            w_zero;
    logic            r_dv [DIV_BITS+1];
    t_tail           r_dt [DIV_BITS+1];
    logic [RW-1:0]   r_rem [DIV_BITS+1];
    logic [LB:0]     r_dtrig [DIV_BITS+1];
    logic [15:0]     r_q [DIV_BITS+1];
    logic [15:0]     w_dist;
    logic            r_out_valid;
    t_out_item       r_out;

    assign w_adv = !(r_out_valid && i_stall);
    assign o_stall = !w_adv;

    srbb_cos #(.ANGLE_BITS(ANGLE_BITS), .LENGTH_BITS(LENGTH_BITS)) u_cos_c (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_phi  (i_job.phi[ANGLE_BITS-2:0]),
        .o_trig (w_c)
    );

    srbb_cos #(.ANGLE_BITS(ANGLE_BITS), .LENGTH_BITS(LENGTH_BITS)) u_cos_s (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_phi  (i_job.phi_c[ANGLE_BITS-2:0]),
        .o_trig (w_s)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < COS_LAT; i++) begin
                r_v[i] <= 1'b0;
            end
            r_e1_v <= 1'b0;
            r_e2_v <= 1'b0;
            for (int i = 0; i <= DIV_BITS; i++) begin
                r_dv[i] <= 1'b0;
            end
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_v[0] <= i_valid;
            for (int i = 1; i < COS_LAT; i++) begin
                r_v[i] <= r_v[i-1];
            end
            r_e1_v <= r_v[COS_LAT-1];
            r_e2_v <= r_e1_v;
            r_dv[0] <= r_e2_v;
            for (int i = 1; i <= DIV_BITS; i++) begin
                r_dv[i] <= r_dv[i-1];
            end
            r_out_valid <= r_dv[DIV_BITS];
        end
    end

    always_comb begin
        w_take_end = r_e1_sb.strict ? (r_lhs < r_rhs) : (r_lhs <= r_rhs);
        w_num = RW'(r_e2_edge) << LB;
        w_sat = w_num >= (RW'(r_e2_trig) << DIV_BITS);
        w_zero = r_e2_edge == '0;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sb[0] <= i_job.side;
            for (int i = 1; i < COS_LAT; i++) begin
                r_sb[i] <= r_sb[i-1];
            end
            r_e1_sb <= r_sb[COS_LAT-1];
            r_lhs <= (16+LW)'(r_sb[COS_LAT-1].dist_end) * (16+LW)'(w_s);
            r_rhs <= (16+LW)'(r_sb[COS_LAT-1].dist_side) * (16+LW)'(w_c);
            r_e1_c <= w_c;
            r_e1_s <= w_s;
            r_e2_sb <= r_e1_sb;
            r_e2_edge <= w_take_end ? r_e1_sb.dist_end : r_e1_sb.dist_side;
            r_e2_trig <= w_take_end ? r_e1_c : r_e1_s;
            r_dt[0].err <= r_e2_sb.err;
            r_dt[0].fix <= r_e2_sb.err || w_zero || w_sat;
            r_dt[0].fix_max <= !r_e2_sb.err && !w_zero && w_sat;
            r_dt[0].range_mm <= r_e2_sb.range_mm;
            r_rem[0] <= w_num;
            r_dtrig[0] <= r_e2_trig;
            r_q[0] <= '0;
        end
    end

    generate
        for (genvar i = 1; i <= DIV_BITS; i++) begin : g_div
            localparam int BIT = DIV_BITS - i;
            logic [RW-1:0] w_sub;
            logic          w_ge;
            assign w_sub = RW'(r_dtrig[i-1]) << BIT;
            assign w_ge = r_rem[i-1] >= w_sub;
            always_ff @(posedge i_clk) begin
                if (w_adv) begin
                    r_dt[i] <= r_dt[i-1];
                    r_dtrig[i] <= r_dtrig[i-1];
                    r_rem[i] <= w_ge ? (r_rem[i-1] - w_sub) : r_rem[i-1];
                    r_q[i] <= r_q[i-1] | (w_ge ? (16'd1 << BIT) : 16'd0);
                end
            end
        end
    endgenerate

    always_comb begin
        if (r_dt[DIV_BITS].fix) begin
            w_dist = r_dt[DIV_BITS].fix_max ? DIST_MAX : 16'd0;
        end else begin
            w_dist = r_q[DIV_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out.body_distance <= w_dist;
            r_out.inside_body <= !r_dt[DIV_BITS].err && (r_dt[DIV_BITS].range_mm < w_dist);
            r_out.shape_error <= r_dt[DIV_BITS].err;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data = r_out;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.shape_error |-> r_out.body_distance == '0 && !r_out.inside_body)
        else $error("shape error with nonzero result");

    a_inside_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.inside_body |-> r_out.body_distance != '0)
        else $error("inside flag with zero distance");

    a_cos_to_e1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[COS_LAT-1] && w_adv |=> r_e1_v)
        else $error("item lost after trig pipeline");

endmodule

[sv/scan_ray_body_boundary_test.sv]
`timescale 1ns / 1ps
// Ray to rectangular body outline distance, top level with register port.
// Throughput: one reading per cycle; the back pipeline holds as a whole on output stall.
// Reset: synchronous active low; clears valid bits, queue pointers and the config.
// Depends on srbb_pkg, srbb_front, srbb_fifo, srbb_back.
module scan_ray_body_boundary_test #(
    parameter int ANGLE_BITS = 16,
    parameter int LENGTH_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  srbb_pkg::t_in_item           i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output srbb_pkg::t_out_item          o_out_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [srbb_pkg::ADDR_W-1:0]  paddr,
    input  logic [srbb_pkg::DATA_W-1:0]  pwdata,
    output logic [srbb_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);
    import srbb_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;
    logic     w_fr_valid;
    logic     w_fr_stall;
    t_job     w_fr_job;
    logic     w_bk_valid;
    logic     w_bk_stall;
    t_job     w_bk_job;

    assign pready = 1'b1;
    assign w_idx = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign w_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_wr) begin
            case (w_idx)
                REG_DIST_FRONT: r_cfg.dist_front <= pwdata[15:0];
                REG_DIST_BACK:  r_cfg.dist_back <= pwdata[15:0];
                REG_DIST_LEFT:  r_cfg.dist_left <= pwdata[15:0];
                REG_DIST_RIGHT: r_cfg.dist_right <= pwdata[15:0];
                REG_SHAPE_MODE: r_cfg.shape_mode <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_DIST_FRONT: prdata = DATA_W'(r_cfg.dist_front);
            REG_DIST_BACK:  prdata = DATA_W'(r_cfg.dist_back);
            REG_DIST_LEFT:  prdata = DATA_W'(r_cfg.dist_left);
            REG_DIST_RIGHT: prdata = DATA_W'(r_cfg.dist_right);
            REG_SHAPE_MODE: prdata = DATA_W'(r_cfg.shape_mode);
            default:        prdata = '0;
        endcase
    end

    srbb_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_data  (i_in_data),
        .i_cfg   (r_cfg),
        .o_valid (w_fr_valid),
        .i_stall (w_fr_stall),
        .o_job   (w_fr_job)
    );

    srbb_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fr_valid),
        .o_stall (w_fr_stall),
        .i_job   (w_fr_job),
        .o_valid (w_bk_valid),
        .i_stall (w_bk_stall),
        .o_job   (w_bk_job)
    );

    srbb_back #(.ANGLE_BITS(ANGLE_BITS), .LENGTH_BITS(LENGTH_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_bk_valid),
        .o_stall (w_bk_stall),
        .i_job   (w_bk_job),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (o_out_data)
    );

endmodule
